FILE: sv/wtsp_pkg.sv
package wtsp_pkg;

	localparam int COORD_FRAC_BITS = 16;
	localparam int COEF_FRAC_BITS  = 12;

	localparam int POS_W    = 32;
	localparam int RAD_W    = 31;
	localparam int COEF_W   = 16;
	localparam int NCOEF    = 4;
	localparam int NAXIS    = 4;
	localparam int VIEW_W   = 14;
	localparam int MARGIN_W = 10;
	localparam int CFG_W    = 64;
	localparam int IDX_W    = 3;

	// clip sums: three products of 33 x 16 bits plus the translation term
	localparam int PROD_W = POS_W + 1 + COEF_W;
	localparam int CLIP_W = PROD_W + 1;
	localparam int MAG_W  = CLIP_W;
	localparam int DEN_W  = CLIP_W;

	// divider
	localparam int B_W     = VIEW_W + COORD_FRAC_BITS;
	localparam int LO_W    = MAG_W / 2;
	localparam int HI_W    = MAG_W - LO_W;
	localparam int P_W     = MAG_W + B_W;
	localparam int QBITS   = 63;
	localparam int DIV_LAT = QBITS + 2;
	localparam logic [QBITS-1:0] QCAP = QBITS'(1) << (QBITS - 1);

	// screen values
	localparam int S_W  = 64;
	localparam int SC_W = 32;
	localparam logic signed [S_W-1:0] I32_MAX = 64'sd2147483647;
	localparam logic signed [S_W-1:0] I32_MIN = -64'sd2147483648;

	// radius
	localparam int D_W   = RAD_W;
	localparam int SQ_W  = 2 * D_W + 1;
	localparam int SQ_N  = (SQ_W + 1) / 2;
	localparam int RES_W = SQ_N;
	localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [IDX_W-1:0] {
		REG_CLIP_X      = 3'd0,
		REG_CLIP_Y      = 3'd1,
		REG_CLIP_Z      = 3'd2,
		REG_CLIP_W      = 3'd3,
		REG_VIEW_WIDTH  = 3'd4,
		REG_VIEW_HEIGHT = 3'd5,
		REG_EDGE_MARGIN = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [NAXIS-1:0][NCOEF-1:0][COEF_W-1:0] coef;
		logic [VIEW_W-1:0]                       width;
		logic [VIEW_W-1:0]                       height;
		logic [MARGIN_W-1:0]                     margin;
	} cfg_t;

	typedef struct packed {
		logic             nx_neg;
		logic [MAG_W-1:0] nx_mag;
		logic             ny_neg;
		logic [MAG_W-1:0] ny_mag;
		logic [DEN_W-1:0] den;
	} point_t;

	typedef struct packed {
		logic   vis;
		logic   evis;
		point_t ctr;
		point_t edg;
	} entry_t;

	typedef struct packed {
		logic vis;
		logic evis;
		logic cxn;
		logic cyn;
		logic exn;
		logic eyn;
	} side_t;

	typedef struct packed {
		logic signed [SC_W-1:0] cx32;
		logic signed [SC_W-1:0] cy32;
		logic                   vis;
		logic                   near;
		logic                   zero;
		logic                   satr;
	} tail_t;

endpackage

FILE: sv/wtsp_intf.sv
interface wtsp_in_if;
	import wtsp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic [RAD_W-1:0]        sphere_radius;
	modport source(output valid, pos_x, pos_y, pos_z, sphere_radius, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, sphere_radius, output ready);
endinterface

interface wtsp_out_if;
	import wtsp_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [SC_W-1:0] screen_x;
	logic signed [SC_W-1:0] screen_y;
	logic                   in_view;
	logic                   near_screen;
	logic [RAD_W-1:0]       screen_radius;
	modport source(output valid, screen_x, screen_y, in_view, near_screen, screen_radius,
		input ready);
	modport sink(input valid, screen_x, screen_y, in_view, near_screen, screen_radius,
		output ready);
endinterface

interface wtsp_cfg_if;
	import wtsp_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [CFG_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/wtsp_front.sv
module wtsp_front (
	input  logic            clk,
	input  logic            arst_n,
	wtsp_in_if.sink         item,
	input  wtsp_pkg::cfg_t  cfg,
	input  logic            full,
	output logic            push,
	output wtsp_pkg::entry_t entry
);
	import wtsp_pkg::*;

	logic                     en;
	logic                     v_s1, v_s2, v_s3;
	logic signed [POS_W-1:0]  px_s1, py_s1, pz_s1;
	logic signed [POS_W:0]    ex_s1;
	logic signed [COEF_W-1:0] k [NAXIS][NCOEF];
	logic signed [PROD_W-1:0] pc_s2 [NAXIS][3];
	logic signed [PROD_W-1:0] pe_s2 [NAXIS];
	logic signed [CLIP_W-1:0] cc_s3 [NAXIS];
	logic signed [CLIP_W-1:0] ce_s3 [NAXIS];

	function automatic point_t mk_point(input logic signed [CLIP_W-1:0] cx, cy, cw);
		logic signed [CLIP_W:0] nx, ny;
		point_t p;
		nx = (CLIP_W+1)'(cx) + (CLIP_W+1)'(cw);
		ny = (CLIP_W+1)'(cw) - (CLIP_W+1)'(cy);
		p.nx_neg = nx[CLIP_W];
		p.nx_mag = nx[CLIP_W] ? MAG_W'(-nx) : MAG_W'(nx);
		p.ny_neg = ny[CLIP_W];
		p.ny_mag = ny[CLIP_W] ? MAG_W'(-ny) : MAG_W'(ny);
		p.den    = {cw[CLIP_W-2:0], 1'b0};
		return p;
	endfunction

	function automatic logic in_depth(input logic signed [CLIP_W-1:0] cz, cw);
		return (cw > 0) && (cz >= 0) && (cz <= cw);
	endfunction

	always_comb begin
		for (int c = 0; c < NAXIS; c++) begin
			for (int r = 0; r < NCOEF; r++) begin
				k[c][r] = cfg.coef[c][r];
			end
		end
	end

	assign en         = !(v_s3 && full);
	assign item.ready = en;
	assign push       = v_s3 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= item.pos_x;
			py_s1 <= item.pos_y;
			pz_s1 <= item.pos_z;
			ex_s1 <= (POS_W+1)'(item.pos_x) + signed'((POS_W+1)'(item.sphere_radius));
			for (int c = 0; c < NAXIS; c++) begin
				pc_s2[c][0] <= PROD_W'(px_s1) * PROD_W'(k[c][0]);
				pc_s2[c][1] <= PROD_W'(py_s1) * PROD_W'(k[c][1]);
				pc_s2[c][2] <= PROD_W'(pz_s1) * PROD_W'(k[c][2]);
				pe_s2[c]    <= PROD_W'(ex_s1) * PROD_W'(k[c][0]);
				// translation row aligned to the coordinate fraction
				cc_s3[c] <= CLIP_W'(pc_s2[c][0]) + CLIP_W'(pc_s2[c][1]) + CLIP_W'(pc_s2[c][2])
					+ (CLIP_W'(k[c][3]) <<< COORD_FRAC_BITS);
				ce_s3[c] <= CLIP_W'(pe_s2[c]) + CLIP_W'(pc_s2[c][1]) + CLIP_W'(pc_s2[c][2])
					+ (CLIP_W'(k[c][3]) <<< COORD_FRAC_BITS);
			end
		end
	end

	always_comb begin
		entry.vis  = in_depth(cc_s3[2], cc_s3[3]);
		entry.evis = in_depth(ce_s3[2], ce_s3[3]);
		entry.ctr  = mk_point(cc_s3[0], cc_s3[1], cc_s3[3]);
		entry.edg  = mk_point(ce_s3[0], ce_s3[1], ce_s3[3]);
	end

endmodule

FILE: sv/wtsp_fifo.sv
module wtsp_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wtsp_pkg::entry_t wdata,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output wtsp_pkg::entry_t rdata
);
	import wtsp_pkg::*;

	entry_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

endmodule

FILE: sv/wtsp_divider.sv
module wtsp_divider (
	input  logic                         clk,
	input  logic                         en,
	input  logic [wtsp_pkg::MAG_W-1:0]   mag,
	input  logic [wtsp_pkg::B_W-1:0]     mul,
	input  logic [wtsp_pkg::DEN_W-1:0]   den,
	output logic [wtsp_pkg::QBITS-1:0]   quo
);
	import wtsp_pkg::*;

	// floor(mag * mul / den), capped at QCAP; one quotient bit per stage
	logic [HI_W+B_W-1:0] ph_s1;
	logic [LO_W+B_W-1:0] pl_s1;
	logic [DEN_W-1:0]    den_s1;
	logic [DEN_W-1:0]    rem_s2, den_s2;
	logic [QBITS-1:0]    low_s2;
	logic                cap_s2;
	logic [P_W-1:0]      prod;
	logic [DEN_W-1:0]    rem_s [QBITS];
	logic [QBITS-1:0]    low_s [QBITS];
	logic [QBITS-1:0]    quo_s [QBITS];
	logic [DEN_W-1:0]    den_s [QBITS];
	logic                cap_s [QBITS];

	assign prod = (P_W'(ph_s1) << LO_W) + P_W'(pl_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1  <= (HI_W+B_W)'(mag[MAG_W-1:LO_W]) * (HI_W+B_W)'(mul);
			pl_s1  <= (LO_W+B_W)'(mag[LO_W-1:0]) * (LO_W+B_W)'(mul);
			den_s1 <= den;
			// quotient of 2^QBITS or more always caps
			cap_s2 <= DEN_W'(prod[P_W-1:QBITS]) >= den_s1;
			rem_s2 <= DEN_W'(prod[P_W-1:QBITS]);
			low_s2 <= prod[QBITS-1:0];
			den_s2 <= den_s1;
		end
	end

	for (genvar g = 0; g < QBITS; g++) begin : g_stage
		logic [DEN_W-1:0] rp, dp;
		logic [QBITS-1:0] lp, qp;
		logic             cp;
		logic [DEN_W:0]   t;
		logic             ge;
		if (g == 0) begin : g_first
			assign rp = rem_s2;
			assign lp = low_s2;
			assign qp = '0;
			assign dp = den_s2;
			assign cp = cap_s2;
		end else begin : g_next
			assign rp = rem_s[g-1];
			assign lp = low_s[g-1];
			assign qp = quo_s[g-1];
			assign dp = den_s[g-1];
			assign cp = cap_s[g-1];
		end
		assign t  = {rp, lp[QBITS-1]};
		assign ge = t >= {1'b0, dp};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= ge ? DEN_W'(t - {1'b0, dp}) : DEN_W'(t);
				low_s[g] <= lp << 1;
				quo_s[g] <= {qp[QBITS-2:0], ge};
				den_s[g] <= dp;
				cap_s[g] <= cp;
			end
		end
	end

	assign quo = (cap_s[QBITS-1] || quo_s[QBITS-1] > QCAP) ? QCAP : quo_s[QBITS-1];

endmodule

FILE: sv/wtsp_isqrt.sv
module wtsp_isqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [wtsp_pkg::SQ_W-1:0]  val,
	output logic [wtsp_pkg::RES_W-1:0] root
);
	import wtsp_pkg::*;

	// digit-by-digit square root, two radicand bits per stage
	logic [SQ_W-1:0] rem_s [SQ_N];
	logic [SQ_W-1:0] res_s [SQ_N];

	for (genvar g = 0; g < SQ_N; g++) begin : g_stage
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_N - 1 - g));
		logic [SQ_W-1:0] vp, rp, trial;
		if (g == 0) begin : g_first
			assign vp = val;
			assign rp = '0;
		end else begin : g_next
			assign vp = rem_s[g-1];
			assign rp = res_s[g-1];
		end
		assign trial = rp + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (vp >= trial) begin
					rem_s[g] <= vp - trial;
					res_s[g] <= (rp >> 1) + BIT;
				end else begin
					rem_s[g] <= vp;
					res_s[g] <= rp >> 1;
				end
			end
		end
	end

	assign root = RES_W'(res_s[SQ_N-1]);

endmodule

FILE: sv/wtsp_back.sv
module wtsp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  wtsp_pkg::cfg_t   cfg,
	input  logic             empty,
	input  wtsp_pkg::entry_t head,
	output logic             pop,
	wtsp_out_if.source       result
);
	import wtsp_pkg::*;

	logic                   en;
	logic [B_W-1:0]         bw, bh;
	logic [QBITS-1:0]       qcx, qcy, qex, qey;
	side_t                  side_in;
	side_t                  side_s [DIV_LAT];
	logic                   dv_s [DIV_LAT];
	logic signed [S_W-1:0]  sx, sy, lowb, hib;
	logic signed [SC_W-1:0] cx32_s1, cy32_s1, ex32_s1, ey32_s1;
	logic                   vis_s1, evis_s1, near_s1;
	logic                   v_s1, v_s2, v_s3, v_s4;
	logic signed [SC_W+1:0] ddx, ddy, adx, ady;
	logic [D_W-1:0]         dx_s2, dy_s2;
	logic [2*D_W-1:0]       sqx_s3, sqy_s3;
	logic [SQ_W-1:0]        sum_s4;
	tail_t                  tl_s2, tl_s3, tl_s4;
	tail_t                  tail_s [SQ_N];
	logic                   sv_s [SQ_N];
	logic [RES_W-1:0]       root;
	logic                   out_valid_q;
	logic signed [SC_W-1:0] sx_q, sy_q;
	logic                   vis_q, near_q;
	logic [RAD_W-1:0]       rad_q;

	function automatic logic signed [S_W-1:0] to_s(input logic neg, input logic [QBITS-1:0] q);
		logic signed [S_W-1:0] m;
		m = signed'(S_W'(q));
		return neg ? -m : m;
	endfunction

	function automatic logic signed [SC_W-1:0] sat32(input logic signed [S_W-1:0] v);
		logic signed [S_W-1:0] c;
		c = (v > I32_MAX) ? I32_MAX : ((v < I32_MIN) ? I32_MIN : v);
		return SC_W'(c);
	endfunction

	assign en  = !out_valid_q || result.ready;
	assign pop = en && !empty;
	assign bw  = B_W'(cfg.width) << COORD_FRAC_BITS;
	assign bh  = B_W'(cfg.height) << COORD_FRAC_BITS;

	wtsp_divider u_div_cx (.clk, .en, .mag(head.ctr.nx_mag), .mul(bw), .den(head.ctr.den),
		.quo(qcx));
	wtsp_divider u_div_cy (.clk, .en, .mag(head.ctr.ny_mag), .mul(bh), .den(head.ctr.den),
		.quo(qcy));
	wtsp_divider u_div_ex (.clk, .en, .mag(head.edg.nx_mag), .mul(bw), .den(head.edg.den),
		.quo(qex));
	wtsp_divider u_div_ey (.clk, .en, .mag(head.edg.ny_mag), .mul(bh), .den(head.edg.den),
		.quo(qey));

	always_comb begin
		side_in.vis  = head.vis;
		side_in.evis = head.evis;
		side_in.cxn  = head.ctr.nx_neg;
		side_in.cyn  = head.ctr.ny_neg;
		side_in.exn  = head.edg.nx_neg;
		side_in.eyn  = head.edg.ny_neg;
	end

	// rejected centre reads as zero; near test uses the capped value
	always_comb begin
		sx   = side_s[DIV_LAT-1].vis ? to_s(side_s[DIV_LAT-1].cxn, qcx) : '0;
		sy   = side_s[DIV_LAT-1].vis ? to_s(side_s[DIV_LAT-1].cyn, qcy) : '0;
		lowb = -(signed'(S_W'(cfg.margin)) <<< COORD_FRAC_BITS);
		hib  = signed'(S_W'(cfg.width) + S_W'(cfg.margin)) <<< COORD_FRAC_BITS;
		ddx  = (SC_W+2)'(ex32_s1) - (SC_W+2)'(cx32_s1);
		ddy  = (SC_W+2)'(ey32_s1) - (SC_W+2)'(cy32_s1);
		adx  = ddx < 0 ? -ddx : ddx;
		ady  = ddy < 0 ? -ddy : ddy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) dv_s[i] <= 1'b0;
			for (int i = 0; i < SQ_N; i++) sv_s[i] <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			dv_s[0] <= !empty;
			for (int i = 1; i < DIV_LAT; i++) dv_s[i] <= dv_s[i-1];
			v_s1    <= dv_s[DIV_LAT-1];
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			sv_s[0] <= v_s4;
			for (int i = 1; i < SQ_N; i++) sv_s[i] <= sv_s[i-1];
			out_valid_q <= sv_s[SQ_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int i = 1; i < DIV_LAT; i++) side_s[i] <= side_s[i-1];

			cx32_s1 <= sat32(sx);
			cy32_s1 <= sat32(sy);
			ex32_s1 <= sat32(to_s(side_s[DIV_LAT-1].exn, qex));
			ey32_s1 <= sat32(to_s(side_s[DIV_LAT-1].eyn, qey));
			vis_s1  <= side_s[DIV_LAT-1].vis;
			evis_s1 <= side_s[DIV_LAT-1].evis;
			near_s1 <= side_s[DIV_LAT-1].vis && sx >= lowb && sx <= hib
				&& sy >= lowb && sy <= (signed'(S_W'(cfg.height) + S_W'(cfg.margin))
				<<< COORD_FRAC_BITS);

			dx_s2      <= D_W'(adx);
			dy_s2      <= D_W'(ady);
			tl_s2.cx32 <= cx32_s1;
			tl_s2.cy32 <= cy32_s1;
			tl_s2.vis  <= vis_s1;
			tl_s2.near <= near_s1;
			tl_s2.zero <= !(vis_s1 && evis_s1);
			tl_s2.satr <= adx > (SC_W+2)'(I32_MAX) || ady > (SC_W+2)'(I32_MAX);

			sqx_s3 <= (2*D_W)'(dx_s2) * (2*D_W)'(dx_s2);
			sqy_s3 <= (2*D_W)'(dy_s2) * (2*D_W)'(dy_s2);
			tl_s3  <= tl_s2;

			sum_s4 <= SQ_W'(sqx_s3) + SQ_W'(sqy_s3);
			tl_s4  <= tl_s3;

			tail_s[0] <= tl_s4;
			for (int i = 1; i < SQ_N; i++) tail_s[i] <= tail_s[i-1];

			sx_q   <= tail_s[SQ_N-1].cx32;
			sy_q   <= tail_s[SQ_N-1].cy32;
			vis_q  <= tail_s[SQ_N-1].vis;
			near_q <= tail_s[SQ_N-1].near;
			if (tail_s[SQ_N-1].zero) rad_q <= '0;
			else if (tail_s[SQ_N-1].satr || root > RES_W'(RAD_MAX)) rad_q <= RAD_MAX;
			else rad_q <= RAD_W'(root);
		end
	end

	wtsp_isqrt u_isqrt (.clk, .en, .val(sum_s4), .root);

	assign result.valid         = out_valid_q;
	assign result.screen_x      = sx_q;
	assign result.screen_y      = sy_q;
	assign result.in_view       = vis_q;
	assign result.near_screen   = near_q;
	assign result.screen_radius = rad_q;

endmodule

FILE: sv/world_to_screen_projection.sv
// channel  modport  beat carries
// item     sink     pos_x, pos_y, pos_z, sphere_radius
// result   source   screen_x, screen_y, in_view, near_screen, screen_radius
// cfg      sink     index, data (register write, always ready)
//
// one beat per cycle in and out unless stalled; a beat passes the front, a queue slot,
// 65 divider stages, 4 radius stages, 32 square root stages and the output register
// latency is set by the 63-stage bit-per-cycle quotient pipeline and the root pipeline
// arst_n clears valids, queue pointers and restores the register defaults
// the front stalls only when the 4-entry queue is full; the back stalls as a whole
// when a finished beat waits on result.ready, the queue absorbs the difference
module world_to_screen_projection (
	input  logic         clk,
	input  logic         arst_n,
	wtsp_in_if.sink      item,
	wtsp_out_if.source   result,
	wtsp_cfg_if.sink     cfg
);
	import wtsp_pkg::*;

	cfg_t   cfg_q;
	entry_t push_entry, head;
	logic   push, full, pop, empty;

	assign cfg.ready = 1'b1;

	// register file; identity matrix and 1280x720 with 100 pixel margin at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NAXIS; c++) begin
				for (int r = 0; r < NCOEF; r++) begin
					cfg_q.coef[c][r] <= (c == r) ? COEF_W'(1 << COEF_FRAC_BITS) : '0;
				end
			end
			cfg_q.width  <= VIEW_W'(1280);
			cfg_q.height <= VIEW_W'(720);
			cfg_q.margin <= MARGIN_W'(100);
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_CLIP_X:      cfg_q.coef[0] <= cfg.data;
				REG_CLIP_Y:      cfg_q.coef[1] <= cfg.data;
				REG_CLIP_Z:      cfg_q.coef[2] <= cfg.data;
				REG_CLIP_W:      cfg_q.coef[3] <= cfg.data;
				REG_VIEW_WIDTH:  cfg_q.width   <= cfg.data[VIEW_W-1:0];
				REG_VIEW_HEIGHT: cfg_q.height  <= cfg.data[VIEW_W-1:0];
				REG_EDGE_MARGIN: cfg_q.margin  <= cfg.data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// clip transform and depth test
	wtsp_front u_front (
		.clk, .arst_n, .item, .cfg(cfg_q), .full, .push, .entry(push_entry)
	);

	// decouples the transform from the divide and radius pipeline
	wtsp_fifo u_fifo (
		.clk, .arst_n, .push, .wdata(push_entry), .full, .pop, .empty, .rdata(head)
	);

	// viewport divide, near-screen test and screen radius
	wtsp_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .empty, .head, .pop, .result
	);

endmodule

FILE: verif/wtsp_checker.sv
`timescale 1ns / 100ps

module wtsp_checker (
	input  logic  clk,
	input  logic  arst_n,
	wtsp_in_if    item,
	wtsp_out_if   result,
	wtsp_cfg_if   cfg,
	output int    errors,
	output int    pending
);
	import wtsp_pkg::*;

	typedef struct {
		logic signed [SC_W-1:0] sx;
		logic signed [SC_W-1:0] sy;
		logic                   vis;
		logic                   near;
		logic [RAD_W-1:0]       rad;
	} screen_t;

	localparam longint unsigned CAP62 = 64'd1 << 62;

	logic [CFG_W-1:0]    axis_coefs [NAXIS];
	logic [VIEW_W-1:0]   vw, vh;
	logic [MARGIN_W-1:0] vmargin;
	screen_t             screen_q [$];

	function automatic longint coef_of(logic [CFG_W-1:0] r, int row);
		logic signed [COEF_W-1:0] c;
		c = r[COEF_W*row +: COEF_W];
		return longint'(c);
	endfunction

	function automatic longint clip_sum(int ax, longint px, longint py, longint pz);
		return px * coef_of(axis_coefs[ax], 0) + py * coef_of(axis_coefs[ax], 1)
			+ pz * coef_of(axis_coefs[ax], 2)
			+ coef_of(axis_coefs[ax], 3) * (longint'(1) <<< COORD_FRAC_BITS);
	endfunction

	// truncated num*b/den with the quotient magnitude capped at 2^62
	function automatic longint scale_div(longint num, longint unsigned b, longint den);
		logic [127:0]    prod, q;
		longint unsigned mag, qm;
		mag  = (num < 0) ? longint'(-num) : longint'(num);
		prod = {64'd0, mag} * {64'd0, b};
		if (prod[127:64] >= 64'(den)) begin
			qm = CAP62;
		end else begin
			q  = prod / {64'd0, 64'(den)};
			qm = (q > {64'd0, CAP62}) ? CAP62 : q[63:0];
		end
		return (num < 0) ? -longint'(qm) : longint'(qm);
	endfunction

	function automatic bit to_screen(longint px, longint py, longint pz,
			output longint sx, output longint sy);
		longint cx, cy, cz, cw;
		cx = clip_sum(0, px, py, pz);
		cy = clip_sum(1, px, py, pz);
		cz = clip_sum(2, px, py, pz);
		cw = clip_sum(3, px, py, pz);
		sx = 0;
		sy = 0;
		if (cw <= 0 || cz < 0 || cz > cw) return 1'b0;
		sx = scale_div(cx + cw, longint'(vw) << COORD_FRAC_BITS, 2 * cw);
		sy = scale_div(cw - cy, longint'(vh) << COORD_FRAC_BITS, 2 * cw);
		return 1'b1;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > I32_MAX) return I32_MAX;
		if (v < I32_MIN) return I32_MIN;
		return v;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b   = CAP62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic screen_t project_point(longint px, longint py, longint pz,
			longint r);
		screen_t         o;
		longint          sx, sy, ex, ey, cx32, cy32, lowb, dx, dy;
		longint unsigned rr;
		bit              vis;
		lowb = -longint'(vmargin) * (longint'(1) << COORD_FRAC_BITS);
		vis  = to_screen(px, py, pz, sx, sy);
		cx32 = clamp32(sx);
		cy32 = clamp32(sy);
		rr   = 0;
		o.near = 1'b0;
		if (vis) begin
			// near test uses the capped value, not the saturated one
			o.near = sx >= lowb
				&& sx <= (longint'(vw) + longint'(vmargin)) << COORD_FRAC_BITS
				&& sy >= lowb
				&& sy <= (longint'(vh) + longint'(vmargin)) << COORD_FRAC_BITS;
			if (to_screen(px + r, py, pz, ex, ey)) begin
				dx = clamp32(ex) - cx32;
				dy = clamp32(ey) - cy32;
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				if (dx > I32_MAX || dy > I32_MAX) begin
					rr = RAD_MAX;
				end else begin
					rr = floor_sqrt(longint'(dx * dx) + longint'(dy * dy));
					if (rr > RAD_MAX) rr = RAD_MAX;
				end
			end
		end
		o.sx  = cx32[SC_W-1:0];
		o.sy  = cy32[SC_W-1:0];
		o.vis = vis;
		o.rad = rr[RAD_W-1:0];
		return o;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors  = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		screen_t e;
		if (!arst_n) begin
			axis_coefs[0] = 64'd4096;
			axis_coefs[1] = 64'd4096 << 16;
			axis_coefs[2] = 64'd4096 << 32;
			axis_coefs[3] = 64'd4096 << 48;
			vw      = 14'd1280;
			vh      = 14'd720;
			vmargin = 10'd100;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.index))
					REG_CLIP_X:      axis_coefs[0] = cfg.data;
					REG_CLIP_Y:      axis_coefs[1] = cfg.data;
					REG_CLIP_Z:      axis_coefs[2] = cfg.data;
					REG_CLIP_W:      axis_coefs[3] = cfg.data;
					REG_VIEW_WIDTH:  vw = cfg.data[VIEW_W-1:0];
					REG_VIEW_HEIGHT: vh = cfg.data[VIEW_W-1:0];
					REG_EDGE_MARGIN: vmargin = cfg.data[MARGIN_W-1:0];
					default: ;
				endcase
			end
			if (item.valid && item.ready)
				screen_q.push_back(project_point(longint'(item.pos_x), longint'(item.pos_y),
					longint'(item.pos_z), longint'({1'b0, item.sphere_radius})));
			if (result.valid && result.ready) begin
				if (screen_q.size() == 0) begin
					report("unexpected beat", 1, 0);
				end else begin
					e = screen_q.pop_front();
					if (result.screen_x !== e.sx) report("screen_x", result.screen_x, e.sx);
					if (result.screen_y !== e.sy) report("screen_y", result.screen_y, e.sy);
					if (result.in_view !== e.vis) report("in_view", result.in_view, e.vis);
					if (result.near_screen !== e.near)
						report("near_screen", result.near_screen, e.near);
					if (result.screen_radius !== e.rad)
						report("screen_radius", result.screen_radius, e.rad);
				end
			end
			pending = screen_q.size();
		end
	end

endmodule

FILE: verif/tb_world_to_screen_projection.sv
`timescale 1ns / 100ps

module tb_world_to_screen_projection;
	import wtsp_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	bit   hold_req;   // asks the result side for one long hold-off
	bit   rx_burst;   // result side never stalls

	wtsp_in_if  item ();
	wtsp_out_if result ();
	wtsp_cfg_if cfg ();

	world_to_screen_projection u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	wtsp_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.result  (result),
		.cfg     (cfg),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// result side: random stalls, one long hold-off on request
	initial begin
		int n;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result.ready <= 1'b0;
				repeat (1500) @(negedge clk);
				hold_req = 1'b0;
				result.ready <= 1'b1;
			end else if (rx_burst) begin
				result.ready <= 1'b1;
			end else begin
				n = gap_len();
				if (n == 0) begin
					result.ready <= 1'b1;
				end else begin
					result.ready <= 1'b0;
					repeat (n - 1) @(negedge clk);
				end
			end
		end
	end

	// called at a falling edge, returns at a falling edge after the beat
	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [30:0] r, bit nogap);
		int n;
		n = nogap ? 0 : gap_len();
		if (n > 0) begin
			item.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		item.valid         <= 1'b1;
		item.pos_x         <= x;
		item.pos_y         <= y;
		item.pos_z         <= z;
		item.sphere_radius <= r;
		do @(posedge clk); while (!item.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= d;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// quiet the item side and wait out everything in flight
	task automatic drain();
		item.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic load_view(logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy,
			logic [CFG_W-1:0] cz, logic [CFG_W-1:0] cw, int w, int h, int m);
		write_reg(REG_CLIP_X, cx);
		write_reg(REG_CLIP_Y, cy);
		write_reg(REG_CLIP_Z, cz);
		write_reg(REG_CLIP_W, cw);
		write_reg(REG_VIEW_WIDTH, CFG_W'(w));
		write_reg(REG_VIEW_HEIGHT, CFG_W'(h));
		write_reg(REG_EDGE_MARGIN, CFG_W'(m));
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// small signed coefficient in a given row, rest zero
	function automatic logic [63:0] row_coef(int row, int lo, int hi);
		logic [63:0] v;
		v = '0;
		v[16*row +: 16] = 16'($signed($urandom_range(0, hi - lo)) + lo);
		return v;
	endfunction

	// mostly points near the frustum with small radii, the rest raw noise
	task automatic random_points(int count, int zmax);
		logic [31:0] x, y, z;
		logic [30:0] r;
		repeat (count) begin
			if ($urandom_range(0, 99) < 75) begin
				x = 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
				y = 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
				z = 32'($signed($urandom_range(0, zmax)) - 256);
				r = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 17));
			end else begin
				x = $urandom;
				y = $urandom;
				z = $urandom;
				r = 31'($urandom);
			end
			send_point(x, y, z, r, 1'b0);
		end
	endtask

	initial begin
		item.valid = 1'b0;
		item.pos_x = '0;
		item.pos_y = '0;
		item.pos_z = '0;
		item.sphere_radius = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_CLIP_X;
		cfg.data  = '0;
		hold_req  = 1'b0;
		rx_burst  = 1'b0;
		arst_n    = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset identity view: depth edges, field extremes, corners
		send_point(32'd0, 32'd0, 32'd0, 31'd0, 1'b1);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 1'b1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0, 1'b1);
		send_point(32'd0, 32'd0, 32'h0001_0000, 31'h0000_8000, 1'b1);   // depth one
		send_point(32'd0, 32'd0, 32'h0001_0001, 31'h0000_8000, 1'b1);   // just past far
		send_point(32'd0, 32'd0, 32'hffff_ffff, 31'h0000_8000, 1'b1);   // just before near
		send_point(32'hffff_0000, 32'h0001_0000, 32'h0000_8000, 31'd1, 1'b1);
		send_point(32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 31'h0002_0000, 1'b0);
		send_point(32'h0001_2000, 32'h0000_0000, 32'h0000_4000, 31'h7fff_ffff, 1'b0);
		send_point(32'hfffe_c000, 32'h0001_4000, 32'h0000_4000, 31'h0000_1000, 1'b0);
		send_point(32'h0000_1234, 32'hffff_edcc, 32'h0000_ffff, 31'h0555_5555, 1'b0);
		send_point(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 31'h2aaa_aaaa, 1'b0);
		random_points(130, 1 << 17);

		// result side holds off for a long stretch while items keep coming
		hold_req = 1'b1;
		random_points(200, 1 << 17);
		drain();

		// identity at an 8192x8192 window and the largest margin
		load_view(64'd4096, 64'd4096 << 16, 64'd4096 << 32, 64'd4096 << 48,
			8192, 8192, 1023);
		rx_burst = 1'b1;
		random_points(150, 1 << 17);
		rx_burst = 1'b0;
		random_points(100, 1 << 17);
		drain();

		// perspective: w follows z, depth half of w, zero width, widest height
		load_view(row_coef(0, -8192, 8192), row_coef(1, -8192, 8192),
			64'd2048 << 32, 64'd4096 << 32, 0, 16383, 0);
		random_points(280, 1 << 22);
		drain();

		// fully random matrix and viewport
		load_view(rand64(), rand64(), rand64(), rand64(),
			$urandom_range(0, 16383), $urandom_range(0, 16383), $urandom_range(0, 1023));
		random_points(250, 1 << 20);
		drain();

		// extreme coefficients
		load_view(64'h8000_7fff_8000_7fff, 64'h7fff_8000_7fff_8000,
			64'h0000_0000_0000_0001, 64'h7fff_7fff_7fff_7fff, 16383, 1, 1023);
		random_points(200, 1 << 20);
		drain();

		// random perspective again, moderate viewport
		load_view(row_coef(0, -16384, 16384) | row_coef(3, -4096, 4096),
			row_coef(1, -16384, 16384) | row_coef(3, -4096, 4096),
			(64'd3000 << 32) | row_coef(3, -4096, 0), 64'd4096 << 32,
			$urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(0, 300));
		random_points(330, 1 << 21);
		drain();

		if (errors == 0 && pending == 0) begin
			$display("[world_to_screen_projection] OK");
		end else begin
			$display("[world_to_screen_projection] ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("[world_to_screen_projection] ERROR");
		$finish;
	end

endmodule

FILE: files.f
sv/wtsp_pkg.sv
sv/wtsp_intf.sv
sv/wtsp_front.sv
sv/wtsp_fifo.sv
sv/wtsp_divider.sv
sv/wtsp_isqrt.sv
sv/wtsp_back.sv
sv/world_to_screen_projection.sv
verif/wtsp_checker.sv
verif/tb_world_to_screen_projection.sv
